FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the frame receiver.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define AFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every edge outside reset, skipping the first edge after it.
`define AFR_ASSERT_PAST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		$past(arst_n) |-> (prop)) else $error(msg);

`endif

FILE: rtl/core/afr_pkg.sv
// Types and constants of the addressed frame receiver.
// No dependencies; imported by the parser, the result queue and the top level.
`timescale 1ns / 1ps
package afr_pkg;

	localparam int CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDRESS   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_FUNCTION = 8'd1;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] station_address;
		logic [7:0] expected_function;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_payload;
		logic       frame_end;
		status_t    frame_status;
		logic [9:0] payload_length;
	} res_t;

endpackage

FILE: rtl/core/addressed_frame_receiver_top.sv
// A result enters the queue at the edge that transfers its byte; from an empty queue
// it sits on the result ports right after that edge and can be popped at the next edge.
// Throughput: one byte per cycle; the parser's per-byte phase update and checksum add
// set that figure, the result queue of QUEUE_DEPTH entries absorbs pop stalls, and
// push stalls only while that queue is full.
// Reset (arst_n low, asynchronous): address hunting, counters and sum cleared,
// queue emptied, station_address = 1, expected_function = 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module addressed_frame_receiver_top #(
	parameter int FRAME_BYTES = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      rx_byte,
	output logic                            empty,
	input  logic                            pop,
	output logic [7:0]                      out_byte,
	output logic                            is_payload,
	output logic                            frame_end,
	output logic [1:0]                      frame_status,
	output logic [9:0]                      payload_length,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [afr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);
	import afr_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cfg_t          cfg_q;
	logic          in_xfer;
	logic          out_xfer;
	logic          res_valid;
	res_t          res;
	res_t          head;
	logic [CW-1:0] count;

	assign cfg_ready = 1'b1;
	assign full      = (count == CW'(QUEUE_DEPTH));
	assign empty     = (count == '0);
	assign in_xfer   = push && !full;
	assign out_xfer  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.station_address   <= 8'd1;
			cfg_q.expected_function <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STATION_ADDRESS:   cfg_q.station_address   <= cfg_data;
				REG_EXPECTED_FUNCTION: cfg_q.expected_function <= cfg_data;
				default: ;
			endcase
		end
	end

	afr_parser #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_xfer),
		.rx_byte  (rx_byte),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	afr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_data(res),
		.rd_en  (out_xfer),
		.rd_data(head),
		.count  (count)
	);

	assign out_byte       = head.out_byte;
	assign is_payload     = head.is_payload;
	assign frame_end      = head.frame_end;
	assign frame_status   = head.frame_status;
	assign payload_length = head.payload_length;

	`AFR_ASSERT(a_result_lands, (res_valid |=> !empty), "result lost before queue")
	`AFR_ASSERT(a_no_result_unaccepted, (res_valid |-> in_xfer), "result without transfer")
	`AFR_ASSERT(a_end_not_payload, (res_valid && res.frame_end |->
		!res.is_payload && res.out_byte == 8'd0), "frame end carries payload")
	`AFR_ASSERT_PAST(a_count_step, (count == $past(count) || count == $past(count) + CW'(1)
		|| count + CW'(1) == $past(count)), "queue count jumped")

endmodule

FILE: rtl/core/afr_parser.sv
// Front part: tracks the frame phase per received byte and classifies it.
// Depends on afr_pkg; emits at most one result per accepted byte.
`timescale 1ns / 1ps
module afr_parser #(
	parameter int FRAME_BYTES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    rx_byte,
	input  afr_pkg::cfg_t cfg,
	output logic          res_valid,
	output afr_pkg::res_t res
);
	import afr_pkg::*;

	localparam int PW = $clog2(FRAME_BYTES) + 1;
	localparam logic [PW-1:0] POS_LIMIT = PW'(FRAME_BYTES);
	localparam logic [PW-1:0] POS_FUNC  = PW'(1);
	localparam logic [PW-1:0] POS_LEN   = PW'(2);
	localparam logic [PW-1:0] POS_LAST_LEN = PW'(5);
	localparam logic [PW-1:0] POS_BODY  = PW'(6);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_FUNC,
		PH_LEN,
		PH_BODY
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [31:0]   len_q, len_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [15:0]   sum_q, sum_d;
	logic [7:0]    cks_lo_q, cks_lo_d;
	logic [32:0]   pay_end;
	logic [32:0]   pos_ext;
	logic [1:0]    len_k;
	logic [15:0]   sum_add;

	assign pay_end = {1'b0, len_q} + 33'd6;
	assign pos_ext = 33'(pos_q);
	assign len_k   = pos_q[1:0] - 2'd2;
	assign sum_add = sum_q + {8'h00, rx_byte};

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		cks_lo_d  = cks_lo_q;
		res_valid = 1'b0;
		res       = '0;
		if (in_valid) begin
			unique case (phase_q)
				PH_HUNT: begin
					phase_d  = PH_HUNT;
					len_d    = '0;
					pos_d    = '0;
					sum_d    = '0;
					cks_lo_d = '0;
					if (rx_byte == cfg.station_address) begin
						sum_d   = {8'h00, rx_byte};
						pos_d   = POS_FUNC;
						phase_d = PH_FUNC;
					end
				end
				PH_FUNC: begin
					if (rx_byte == cfg.expected_function) begin
						sum_d   = sum_add;
						pos_d   = POS_LEN;
						len_d   = '0;
						phase_d = PH_LEN;
					end else begin
						phase_d  = PH_HUNT;
						len_d    = '0;
						pos_d    = '0;
						sum_d    = '0;
						cks_lo_d = '0;
					end
				end
				PH_LEN: begin
					len_d = len_q | ({24'h000000, rx_byte} << {len_k, 3'b000});
					sum_d = sum_add;
					pos_d = pos_q + PW'(1);
					if (pos_q == POS_LAST_LEN) begin
						pos_d   = POS_BODY;
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					if (pos_q >= POS_LIMIT) begin
						phase_d            = PH_HUNT;
						len_d              = '0;
						pos_d              = '0;
						sum_d              = '0;
						cks_lo_d           = '0;
						res_valid          = 1'b1;
						res.frame_end      = 1'b1;
						res.frame_status   = ST_TOO_LONG;
					end else if (pos_ext < pay_end) begin
						sum_d          = sum_add;
						pos_d          = pos_q + PW'(1);
						res_valid      = 1'b1;
						res.out_byte   = rx_byte;
						res.is_payload = 1'b1;
					end else if (pos_ext == pay_end) begin
						cks_lo_d = rx_byte;
						pos_d    = pos_q + PW'(1);
					end else begin
						phase_d            = PH_HUNT;
						len_d              = '0;
						pos_d              = '0;
						sum_d              = '0;
						cks_lo_d           = '0;
						res_valid          = 1'b1;
						res.frame_end      = 1'b1;
						res.frame_status   = ({rx_byte, cks_lo_q} == sum_q) ? ST_GOOD
							: ST_MISMATCH;
						res.payload_length = len_q[9:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_q    <= '0;
			pos_q    <= '0;
			sum_q    <= '0;
			cks_lo_q <= '0;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			cks_lo_q <= cks_lo_d;
		end
	end

endmodule

FILE: rtl/core/afr_queue.sv
// Back part: short result queue between the parser and the result ports.
// Depends on afr_pkg; the head entry drives the result ports directly.
`timescale 1ns / 1ps
module afr_queue #(
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  afr_pkg::res_t              wr_data,
	input  logic                       rd_en,
	output afr_pkg::res_t              rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import afr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
